// File: hw/rtl/pcc_pkg.sv
package pcc_pkg;

    localparam int PCC_COORD_WIDTH = 16;
    localparam int COUNT_W         = 2;
    localparam int STATUS_W        = 2;
    localparam int NUM_TURNS       = 3;

    localparam logic [COUNT_W-1:0] COUNT_SAT = COUNT_W'(3);

    localparam logic [STATUS_W-1:0] STATUS_CONVEX     = STATUS_W'(0);
    localparam logic [STATUS_W-1:0] STATUS_NOT_CONVEX = STATUS_W'(1);
    localparam logic [STATUS_W-1:0] STATUS_SHORT      = STATUS_W'(2);

    // turn indexes: at the previous vertex, and the two closing turns
    localparam int TURN_MID   = 0;
    localparam int TURN_LAST  = 1;
    localparam int TURN_FIRST = 2;

    typedef enum logic [1:0] {
        KIND_NONE,
        KIND_REF,
        KIND_CHECK
    } t_kind;

    typedef struct packed {
        logic pos;
        logic neg;
    } t_sign;

    function automatic logic sign_opposes(t_sign s, t_sign ref_sign);
        return (ref_sign.pos & s.neg) | (ref_sign.neg & s.pos);
    endfunction

endpackage

// File: hw/rtl/polygon_convexity_check.sv
// channel  | valid    | stall    | payload
// ---------+----------+----------+-------------------------------------------
// vertex   | i_valid  | o_stall  | i_vertex_x, i_vertex_y, i_last_vertex
// status   | o_valid  | i_stall  | o_status
//
// one vertex beat per cycle while o_stall is low; each turn costs two multiplies in a stage of their own
// the status beat is registered once the last vertex has passed the difference and product stages
// synchronous reset clears the stage valids, status valid, vertex count, reference sign and failure flag
// a held status beat only blocks the pipeline once a last vertex reaches the product stage
module polygon_convexity_check import pcc_pkg::*; #(
    parameter int COORD_WIDTH = PCC_COORD_WIDTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic signed [COORD_WIDTH-1:0] i_vertex_x,
    input  logic signed [COORD_WIDTH-1:0] i_vertex_y,
    input  logic                          i_last_vertex,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic        [STATUS_W-1:0]    o_status
);

    localparam int DW = COORD_WIDTH + 1;
    localparam int PW = 2 * DW;

    typedef logic signed [COORD_WIDTH-1:0] t_coord;
    typedef logic signed [DW-1:0]          t_diff;
    typedef logic signed [PW-1:0]          t_prod;

    // vertex history
    t_coord             r_first_x, r_first_y, r_second_x, r_second_y;
    t_coord             r_older_x, r_older_y, r_recent_x, r_recent_y;
    logic [COUNT_W-1:0] r_count;

    // difference stage
    logic               r_v1;
    t_kind              r_kind1;
    logic               r_last1, r_wrap1;
    t_diff              r_dx1 [NUM_TURNS];
    t_diff              r_dy1 [NUM_TURNS];
    t_diff              r_dx2 [NUM_TURNS];
    t_diff              r_dy2 [NUM_TURNS];

    // product stage
    logic               r_v2;
    t_kind              r_kind2;
    logic               r_last2, r_wrap2;
    t_prod              r_p [NUM_TURNS];
    t_prod              r_q [NUM_TURNS];

    // turn state and result
    t_sign              r_ref;
    logic               r_failed;
    logic               r_ov;
    logic [STATUS_W-1:0] r_status;

    logic               out_free, move2, en2, en1, acc;
    t_kind              n_kind;
    t_coord             ax [NUM_TURNS];
    t_coord             ay [NUM_TURNS];
    t_coord             bx [NUM_TURNS];
    t_coord             by [NUM_TURNS];
    t_coord             cx [NUM_TURNS];
    t_coord             cy [NUM_TURNS];
    t_sign              s [NUM_TURNS];
    t_sign              n_ref;
    logic               n_failed;
    logic [STATUS_W-1:0] n_status;

    assign out_free = !r_ov || !i_stall;
    assign move2    = r_v2 && (!r_last2 || out_free);
    assign en2      = !r_v2 || move2;
    assign en1      = !r_v1 || en2;
    assign acc      = i_valid && en1;

    assign o_stall  = !en1;
    assign o_valid  = r_ov;
    assign o_status = r_status;

    // turn vertices a, b, c for each of the three turns
    always_comb begin
        ax[TURN_MID]   = r_older_x;  ay[TURN_MID]   = r_older_y;
        bx[TURN_MID]   = r_recent_x; by[TURN_MID]   = r_recent_y;
        cx[TURN_MID]   = i_vertex_x; cy[TURN_MID]   = i_vertex_y;
        ax[TURN_LAST]  = r_recent_x; ay[TURN_LAST]  = r_recent_y;
        bx[TURN_LAST]  = i_vertex_x; by[TURN_LAST]  = i_vertex_y;
        cx[TURN_LAST]  = r_first_x;  cy[TURN_LAST]  = r_first_y;
        ax[TURN_FIRST] = i_vertex_x; ay[TURN_FIRST] = i_vertex_y;
        bx[TURN_FIRST] = r_first_x;  by[TURN_FIRST] = r_first_y;
        cx[TURN_FIRST] = r_second_x; cy[TURN_FIRST] = r_second_y;
    end

    always_comb begin
        if (r_count inside {COUNT_W'(0), COUNT_W'(1)}) begin
            n_kind = KIND_NONE;
        end else if (r_count == COUNT_W'(2)) begin
            n_kind = KIND_REF;
        end else begin
            n_kind = KIND_CHECK;
        end
    end

    // vertex history and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (acc) begin
            if (r_count == COUNT_W'(0)) begin
                r_first_x <= i_vertex_x;
                r_first_y <= i_vertex_y;
            end
            if (r_count == COUNT_W'(1)) begin
                r_second_x <= i_vertex_x;
                r_second_y <= i_vertex_y;
            end
            r_older_x  <= r_recent_x;
            r_older_y  <= r_recent_y;
            r_recent_x <= i_vertex_x;
            r_recent_y <= i_vertex_y;
            if (i_last_vertex) begin
                r_count <= '0;
            end else if (r_count != COUNT_SAT) begin
                r_count <= r_count + COUNT_W'(1);
            end
        end
    end

    // edge differences
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (en1) begin
            r_v1 <= acc;
        end
        if (acc) begin
            r_kind1 <= n_kind;
            r_last1 <= i_last_vertex;
            r_wrap1 <= i_last_vertex && (r_count >= COUNT_W'(2));
            for (int t = 0; t < NUM_TURNS; t++) begin
                r_dx1[t] <= DW'(bx[t]) - DW'(ax[t]);
                r_dy1[t] <= DW'(by[t]) - DW'(ay[t]);
                r_dx2[t] <= DW'(cx[t]) - DW'(bx[t]);
                r_dy2[t] <= DW'(cy[t]) - DW'(by[t]);
            end
        end
    end

    // cross product halves
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (en2) begin
            r_v2 <= r_v1;
        end
        if (en2 && r_v1) begin
            r_kind2 <= r_kind1;
            r_last2 <= r_last1;
            r_wrap2 <= r_wrap1;
            for (int t = 0; t < NUM_TURNS; t++) begin
                r_p[t] <= PW'(r_dx1[t]) * PW'(r_dy2[t]);
                r_q[t] <= PW'(r_dy1[t]) * PW'(r_dx2[t]);
            end
        end
    end

    always_comb begin
        for (int t = 0; t < NUM_TURNS; t++) begin
            s[t].pos = r_p[t] > r_q[t];
            s[t].neg = r_p[t] < r_q[t];
        end
        n_ref    = (r_kind2 == KIND_REF) ? s[TURN_MID] : r_ref;
        n_failed = r_failed
                 | ((r_kind2 == KIND_CHECK) && sign_opposes(s[TURN_MID], r_ref))
                 | (r_wrap2 && (sign_opposes(s[TURN_LAST], n_ref)
                              | sign_opposes(s[TURN_FIRST], n_ref)));
        if (!r_wrap2) begin
            n_status = STATUS_SHORT;
        end else if (n_failed) begin
            n_status = STATUS_NOT_CONVEX;
        end else begin
            n_status = STATUS_CONVEX;
        end
    end

    // turn state and status beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ref    <= '0;
            r_failed <= 1'b0;
            r_ov     <= 1'b0;
        end else begin
            if (move2) begin
                if (r_last2) begin
                    r_ref    <= '0;
                    r_failed <= 1'b0;
                end else begin
                    r_ref    <= n_ref;
                    r_failed <= n_failed;
                end
            end
            if (move2 && r_last2) begin
                r_ov <= 1'b1;
            end else if (!i_stall) begin
                r_ov <= 1'b0;
            end
        end
        if (move2 && r_last2) begin
            r_status <= n_status;
        end
    end

    a_last_clears_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc && i_last_vertex |=> r_count == COUNT_W'(0))
        else $error("vertex count not cleared after last vertex");

    a_count_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !acc |=> $stable(r_count))
        else $error("vertex count moved without a beat");

    a_turn_state_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        move2 && r_last2 |=> r_ref == '0 && !r_failed)
        else $error("turn state not cleared after last vertex");

    a_held_last_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v2 && r_last2 && r_ov && i_stall |=> r_v2 && r_last2)
        else $error("last vertex dropped while status beat held");

    a_short_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        move2 && r_last2 && !r_wrap2 |=> r_ov && r_status == STATUS_SHORT)
        else $error("short polygon did not give short status");

endmodule

// File: tb/sv/polygon_convexity_check_tb.sv
`timescale 1ns / 100ps

module polygon_convexity_check_tb;
    import pcc_pkg::*;

    localparam int CW          = PCC_COORD_WIDTH;
    localparam int CYCLE_LIMIT = 400000;
    localparam int RANDOM_BEATS = 740;

    typedef logic signed [CW-1:0] t_coord;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_valid = 1'b0;
    logic                o_stall;
    t_coord              i_vertex_x = '0;
    t_coord              i_vertex_y = '0;
    logic                i_last_vertex = 1'b0;
    logic                o_valid;
    logic                i_stall = 1'b0;
    logic [STATUS_W-1:0] o_status;

    polygon_convexity_check #(.COORD_WIDTH(CW)) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_vertex_x    (i_vertex_x),
        .i_vertex_y    (i_vertex_y),
        .i_last_vertex (i_last_vertex),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_status      (o_status)
    );

    always #6 i_clk = ~i_clk;

    // polygon tracker state
    t_coord              vtx0_x, vtx0_y, vtx1_x, vtx1_y;
    t_coord              prev2_x, prev2_y, prev1_x, prev1_y;
    logic [COUNT_W-1:0]  track_count;
    t_sign               ref_turn;
    logic                convexity_broken;
    logic [STATUS_W-1:0] status_expected[$];

    t_coord poly_x[$];
    t_coord poly_y[$];
    int     vertices_sent = 0;
    int     mismatch_count = 0;
    int     cycle_count = 0;
    int     burst_left = 0;
    bit     gaps_on = 1'b1;
    int     hold_req = 0;
    int     hold_left = 0;
    int     pattern_left = 0;
    int     stall_pct = 0;

    function automatic t_sign turn_of(t_coord ax, t_coord ay, t_coord bx, t_coord by,
                                      t_coord cx, t_coord cy);
        longint turn_area;
        t_sign  s;
        turn_area = (longint'(bx) - longint'(ax)) * (longint'(cy) - longint'(by))
                  - (longint'(by) - longint'(ay)) * (longint'(cx) - longint'(bx));
        s.pos = (turn_area > 0);
        s.neg = (turn_area < 0);
        return s;
    endfunction

    task automatic note_turn(input t_sign s);
        if ((ref_turn.pos && s.neg) || (ref_turn.neg && s.pos))
            convexity_broken = 1'b1;
    endtask

    task automatic clear_polygon();
        vtx0_x = '0; vtx0_y = '0; vtx1_x = '0; vtx1_y = '0;
        prev2_x = '0; prev2_y = '0; prev1_x = '0; prev1_y = '0;
        track_count = '0;
        ref_turn = '0;
        convexity_broken = 1'b0;
    endtask

    task automatic track_vertex(input t_coord x, input t_coord y, input logic last);
        t_sign s;
        case (track_count)
            COUNT_W'(0): begin
                vtx0_x = x; vtx0_y = y;
            end
            COUNT_W'(1): begin
                vtx1_x = x; vtx1_y = y;
            end
            default: begin
                s = turn_of(prev2_x, prev2_y, prev1_x, prev1_y, x, y);
                if (track_count == COUNT_W'(2))
                    ref_turn = s;
                else
                    note_turn(s);
            end
        endcase
        if (!last) begin
            prev2_x = prev1_x; prev2_y = prev1_y;
            prev1_x = x;       prev1_y = y;
            if (track_count != COUNT_SAT)
                track_count = track_count + 1'b1;
        end else begin
            if (track_count < COUNT_W'(2)) begin
                status_expected.push_back(STATUS_SHORT);
            end else begin
                note_turn(turn_of(prev1_x, prev1_y, x, y, vtx0_x, vtx0_y));
                note_turn(turn_of(x, y, vtx0_x, vtx0_y, vtx1_x, vtx1_y));
                status_expected.push_back(convexity_broken ? STATUS_NOT_CONVEX
                                                           : STATUS_CONVEX);
            end
            clear_polygon();
        end
    endtask

    task automatic send_vertex(input t_coord x, input t_coord y, input logic last);
        int gap;
        if (gaps_on && burst_left == 0) begin
            gap = $urandom_range(1, 6);
            burst_left = $urandom_range(1, 24);
            @(negedge i_clk);
            i_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        if (burst_left > 0)
            burst_left--;
        @(negedge i_clk);
        i_valid       <= 1'b1;
        i_vertex_x    <= x;
        i_vertex_y    <= y;
        i_last_vertex <= last;
        do @(posedge i_clk); while (o_stall !== 1'b0);
        track_vertex(x, y, last);
        vertices_sent++;
    endtask

    task automatic add_vertex(input int x, input int y);
        poly_x.push_back(t_coord'(x));
        poly_y.push_back(t_coord'(y));
    endtask

    task automatic send_polygon();
        int i;
        for (i = 0; i < poly_x.size(); i++)
            send_vertex(poly_x[i], poly_y[i], i == poly_x.size() - 1);
        poly_x.delete();
        poly_y.delete();
    endtask

    function automatic int pick_coord();
        int corner[7] = '{-32768, -32767, -1, 0, 1, 32766, 32767};
        if ($urandom_range(0, 4) == 0)
            return corner[$urandom_range(0, 6)];
        return int'(t_coord'($urandom()));
    endfunction

    task automatic build_noise(input int n);
        int i;
        for (i = 0; i < n; i++)
            add_vertex(pick_coord(), pick_coord());
    endtask

    // convex-curve vertices, x-sorted, reflected, rotated; dent moves one
    task automatic build_convex(input int n, input bit dent);
        int     span, x0, yrange, y0, i, rot, room;
        longint half, scale, mid, xv, d;
        bit     flip_x, flip_y, swap_xy;
        t_coord cx[$], cy[$], tx, ty;
        span   = $urandom_range(2 * n, 65535);
        x0     = $urandom_range(0, 65535 - span) - 32768;
        yrange = $urandom_range(1, 65535);
        y0     = $urandom_range(0, 65535 - yrange) - 32768;
        half   = span / 2 + 1;
        scale  = (half * half) / yrange + 1;
        mid    = x0 + span / 2;
        flip_x  = $urandom_range(0, 1);
        flip_y  = $urandom_range(0, 1);
        swap_xy = $urandom_range(0, 1);
        xv = x0;
        for (i = 0; i < n; i++) begin
            if (i > 0) begin
                room = int'((x0 + span - xv) / (n - i));
                xv += $urandom_range(1, room < 1 ? 1 : room);
            end
            d  = xv - mid;
            tx = t_coord'(xv);
            ty = t_coord'(y0 + d * d / scale);
            if (flip_x) tx = ~tx;
            if (flip_y) ty = ~ty;
            if (swap_xy) begin
                cx.push_back(ty);
                cy.push_back(tx);
            end else begin
                cx.push_back(tx);
                cy.push_back(ty);
            end
        end
        if (dent) begin
            i = $urandom_range(0, n - 1);
            cx[i] = t_coord'(pick_coord());
            cy[i] = t_coord'(pick_coord());
        end
        rot = $urandom_range(0, n - 1);
        for (i = 0; i < n; i++)
            add_vertex(cx[(i + rot) % n], cy[(i + rot) % n]);
    endtask

    task automatic test_short_polygons();
        add_vertex(-32768, 32767);
        send_polygon();
        add_vertex(32767, -32768);
        add_vertex(0, 0);
        send_polygon();
    endtask

    task automatic test_triangles();
        add_vertex(0, 0);
        add_vertex(100, 0);
        add_vertex(0, 100);
        send_polygon();
        add_vertex(0, 0);
        add_vertex(0, 100);
        add_vertex(100, 0);
        send_polygon();
    endtask

    task automatic test_extreme_square();
        add_vertex(-32768, -32768);
        add_vertex(32767, -32768);
        add_vertex(32767, 32767);
        add_vertex(-32768, 32767);
        send_polygon();
    endtask

    task automatic test_concave_closing_turn();
        add_vertex(0, 0);
        add_vertex(10, 0);
        add_vertex(10, 10);
        add_vertex(5, 2);
        send_polygon();
    endtask

    task automatic test_zero_first_turn();
        add_vertex(0, 0);
        add_vertex(1, 1);
        add_vertex(2, 2);
        add_vertex(5, 0);
        add_vertex(0, 5);
        send_polygon();
    endtask

    task automatic test_status_backpressure();
        int i;
        gaps_on  = 1'b0;
        hold_req = 400;
        for (i = 0; i < 30; i++) begin
            build_convex(3, 1'b0);
            send_polygon();
        end
        gaps_on = 1'b1;
    endtask

    task automatic test_random_polygons();
        int target, kind, n;
        target = vertices_sent + RANDOM_BEATS;
        while (vertices_sent < target) begin
            gaps_on = ($urandom_range(0, 4) != 0);
            kind    = $urandom_range(0, 99);
            n       = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 60)
                                                  : $urandom_range(3, 8);
            if (kind < 70)
                build_convex(n, 1'b0);
            else if (kind < 82)
                build_convex(n, 1'b1);
            else if (kind < 94)
                build_noise($urandom_range(1, 10));
            else
                build_noise($urandom_range(1, 2));
            send_polygon();
        end
        gaps_on = 1'b1;
    endtask

    // status receiver stall pattern
    always @(negedge i_clk) begin
        if (hold_req != 0) begin
            hold_left = hold_req;
            hold_req  = 0;
        end
        if (pattern_left == 0) begin
            pattern_left = $urandom_range(16, 96);
            case ($urandom_range(0, 3))
                0: stall_pct = 0;
                1: stall_pct = 20;
                2: stall_pct = 50;
                default: stall_pct = 85;
            endcase
        end
        pattern_left--;
        if (hold_left > 0) begin
            i_stall <= 1'b1;
            hold_left--;
        end else begin
            i_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    // status beat check
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid === 1'b1 && i_stall === 1'b0) begin
            if (status_expected.size() == 0) begin
                $display("%0t status beat: expected none actual %0d", $time, o_status);
                mismatch_count++;
            end else begin
                if (o_status !== status_expected[0]) begin
                    $display("%0t status: expected %0d actual %0d",
                             $time, status_expected[0], o_status);
                    mismatch_count++;
                end
                void'(status_expected.pop_front());
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("polygon_convexity_check: mismatch");
            $finish;
        end
    end

    initial begin
        clear_polygon();
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_short_polygons();
        test_triangles();
        test_extreme_square();
        test_concave_closing_turn();
        test_zero_first_turn();
        test_status_backpressure();
        test_random_polygons();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (status_expected.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("polygon_convexity_check: match");
        else
            $display("polygon_convexity_check: mismatch");
        $finish;
    end

endmodule
